### rtl/dvgr_pkg.sv
// Shared types and constants for the direction vector gcd reduce block.
package dvgr_pkg;
  localparam int DIMS = 4;
  localparam int CW = 8;   // component width
  localparam int MW = 9;   // magnitude / result width
  localparam int CTRW = 5; // step counter width

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } state_t;

  // Lane control from the sequencer.
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
  } lane_ctl_t;
endpackage

### rtl/direction_vector_gcd_reduce.sv
// Top level: sequencer, gcd unit and DIMS divide lanes.
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | comp_0..comp_3
//  out     | out_valid | out_stall | unit_0..unit_3, all_zero
// One request at a time: load, gcd fold (an index walk over the lanes with subtract
// steps for each merged pair), then shared-step division in all lanes at once,
// then the result is held until taken.
// rst is synchronous and clears the sequencer and valid flags.
// in_stall is high from acceptance until the result has been taken.
module direction_vector_gcd_reduce import dvgr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] comp_0,
  input  logic signed [CW-1:0] comp_1,
  input  logic signed [CW-1:0] comp_2,
  input  logic signed [CW-1:0] comp_3,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [MW-1:0] unit_0,
  output logic signed [MW-1:0] unit_1,
  output logic signed [MW-1:0] unit_2,
  output logic signed [MW-1:0] unit_3,
  output logic                 all_zero
);
  state_t state, state_next;
  lane_ctl_t ctl;
  logic [CTRW-1:0] cnt;
  logic gcd_start, gcd_done;
  logic [MW-1:0] gcd;
  logic [MW-1:0] mags [DIMS];
  logic signed [MW-1:0] units [DIMS];
  logic signed [CW-1:0] comps [DIMS];

  assign comps[0] = comp_0;
  assign comps[1] = comp_1;
  assign comps[2] = comp_2;
  assign comps[3] = comp_3;

  for (genvar k = 0; k < DIMS; k++) begin : g_lane
    dvgr_lane u_lane (
      .clk(clk), .ctl(ctl), .comp(comps[k]), .div(gcd),
      .mag(mags[k]), .unit(units[k])
    );
  end

  dvgr_gcd u_gcd (
    .clk(clk), .rst(rst), .start(gcd_start), .mags(mags),
    .done(gcd_done), .gcd(gcd)
  );

  // Merge: zero gcd means all components were zero.
  assign all_zero = (gcd == '0);
  assign unit_0 = all_zero ? '0 : units[0];
  assign unit_1 = all_zero ? '0 : units[1];
  assign unit_2 = all_zero ? '0 : units[2];
  assign unit_3 = all_zero ? '0 : units[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (ctl.div_start) cnt <= '0;
      else if (ctl.div_step) cnt <= cnt + 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    ctl           = '0;
    gcd_start     = 1'b0;
    in_stall      = (state != ST_IDLE);
    out_valid     = (state == ST_OUT);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_GCD;
          gcd_start  = 1'b1;
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          ctl.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt == CTRW'(MW - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

### rtl/dvgr_gcd.sv
// Shared Euclid unit: folds lane magnitudes into one gcd, one subtract step a cycle.
module dvgr_gcd import dvgr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] mags [DIMS],
  output logic          done,
  output logic [MW-1:0] gcd
);
  localparam int IW = $clog2(DIMS + 1);
  logic [MW-1:0] a;
  logic [MW-1:0] b;
  logic [IW-1:0] idx;
  logic busy;
  logic [MW-1:0] cur;

  always_comb begin
    cur = '0;
    for (int k = 0; k < DIMS; k++) begin
      if (idx == IW'(k)) cur = mags[k];
    end
  end

  assign gcd = a;

  // Binary-free Euclid by subtraction: a holds running gcd, b the partner.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        a    <= '0;
        b    <= '0;
        idx  <= '0;
      end else if (busy) begin
        if (b != '0) begin
          // equal pair: a already holds the gcd
          if (a == b) b <= '0;
          else if (a > b) a <= a - b;
          else begin
            a <= b;
            b <= a;
          end
        end else if (idx == IW'(DIMS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (cur != '0) begin
            if (a == '0) a <= cur;
            else b <= cur;
          end
          idx <= idx + 1'b1;
        end
      end
    end
  end
endmodule

### rtl/dvgr_lane.sv
// One lane: holds a component and divides its magnitude by the gcd, restoring style.
module dvgr_lane import dvgr_pkg::*; (
  input  logic                 clk,
  input  lane_ctl_t            ctl,
  input  logic signed [CW-1:0] comp,
  input  logic [MW-1:0]        div,
  output logic [MW-1:0]        mag,
  output logic signed [MW-1:0] unit
);
  logic          neg;
  logic [MW-1:0] quo;
  logic [MW-1:0] rem;
  logic [MW:0]   trial;

  assign trial = {rem, quo[MW-1]} - {1'b0, div};
  assign unit  = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg <= comp[CW-1];
      mag <= comp[CW-1] ? MW'(-$signed({comp[CW-1], comp})) : MW'(comp);
    end
    if (ctl.div_start) begin
      quo <= mag;
      rem <= '0;
    end else if (ctl.div_step) begin
      if (!trial[MW]) begin
        rem <= trial[MW-1:0];
        quo <= {quo[MW-2:0], 1'b1};
      end else begin
        rem <= {rem[MW-2:0], quo[MW-1]};
        quo <= {quo[MW-2:0], 1'b0};
      end
    end
  end
endmodule
